// File: src/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// shared types and constants of the music and effect voice mixer
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned MAX_VOICES    = 7;
  localparam int unsigned VOICES_DEF    = 7;
  localparam int unsigned POS_BITS_DEF  = 24;
  localparam int unsigned POS_OUT_W     = 24;
  localparam int unsigned LEN_W         = 25;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned TERM_W        = 9;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned GAIN_SHIFT    = 6;
  localparam int unsigned NUM_REGS      = MAX_VOICES + 1;
  localparam int unsigned REG_IDX_W     = 3;
  localparam int unsigned ADDR_W        = REG_IDX_W + 2;
  localparam int unsigned DATA_W        = 32;

  localparam logic [COUNT_W-1:0]       COUNT_MAX = 4'd15;
  localparam logic signed [TERM_W-1:0] CENTER    = 9'sd127;
  localparam logic [LEN_W-1:0]         LEN_RESET = 25'd1;

  // request kinds
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_TRIGGER = 1'b1
  } op_t;

  // what one voice lane reports for the tick in flight
  typedef struct packed {
    logic                     active;
    logic [POS_OUT_W-1:0]     pos;
    logic signed [TERM_W-1:0] term;
  } lane_res_t;

  // one finished result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]              sample;
    logic [MAX_VOICES-1:0]                   active;
    logic [POS_OUT_W-1:0]                    music_pos;
    logic [MAX_VOICES-1:0][POS_OUT_W-1:0]    effect_pos;
  } res_t;

endpackage

// File: src/looping_music_and_effect_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// looping_music_and_effect_voice_mixer_unit
// looping music track plus one-shot effect voices mixed to a 16-bit sample
// ----------------------------------------------------------------------------
// a tick request's result is registered in the output or skid entry on accept
// throughput: one request per cycle while in_stall is low, held only by the
//   two-entry output register pair (in_stall only when both are full)
// trigger requests produce no result and take effect for the next request
// reset: positions and play counts go to zero, all lengths to one, no result
// ----------------------------------------------------------------------------
module looping_music_and_effect_voice_mixer_unit #(
  parameter int unsigned VOICES        = mvm_pkg::VOICES_DEF,
  parameter int unsigned POSITION_BITS = mvm_pkg::POS_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [2:0]                   in_voice_select,
  input  logic [3:0]                   in_plays_added,
  input  logic [7:0]                   in_music_byte,
  input  logic [7:0]                   in_effect_byte_0,
  input  logic [7:0]                   in_effect_byte_1,
  input  logic [7:0]                   in_effect_byte_2,
  input  logic [7:0]                   in_effect_byte_3,
  input  logic [7:0]                   in_effect_byte_4,
  input  logic [7:0]                   in_effect_byte_5,
  input  logic [7:0]                   in_effect_byte_6,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           out_mixed_sample,
  output logic [6:0]                   out_voices_active,
  output logic [23:0]                  out_music_position,
  output logic [23:0]                  out_effect_position_0,
  output logic [23:0]                  out_effect_position_1,
  output logic [23:0]                  out_effect_position_2,
  output logic [23:0]                  out_effect_position_3,
  output logic [23:0]                  out_effect_position_4,
  output logic [23:0]                  out_effect_position_5,
  output logic [23:0]                  out_effect_position_6,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvm_pkg::DATA_W-1:0]   pwdata,
  output logic [mvm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import mvm_pkg::*;

  // length registers: entry 0 is the music track, entries 1..7 the voices
  logic [LEN_W-1:0]         len_r [NUM_REGS];
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     reg_wr;

  logic                     in_acc;
  logic                     tick;
  logic                     trigger;
  logic [7:0]               effect_byte [MAX_VOICES];

  // music position, always advancing on a tick
  logic [POSITION_BITS-1:0] music_pos_r, music_pos_step;
  logic                     music_ended;
  logic signed [TERM_W-1:0] music_term;

  lane_res_t [MAX_VOICES-1:0] lane_res;
  res_t                       out_res;
  logic                       mix_full;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;
  assign prdata  = DATA_W'(len_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        len_r[i] <= LEN_RESET;
      end
    end else if (reg_wr) begin
      len_r[reg_idx] <= pwdata[LEN_W-1:0];
    end
  end

  // ---------------- request decode ----------------
  // the skid entry being full is the only reason to hold off requests
  assign in_stall = mix_full;
  assign in_acc   = in_valid && !in_stall;
  assign tick     = in_acc && (in_op == OP_TICK);
  assign trigger  = in_acc && (in_op == OP_TRIGGER);

  assign effect_byte[0] = in_effect_byte_0;
  assign effect_byte[1] = in_effect_byte_1;
  assign effect_byte[2] = in_effect_byte_2;
  assign effect_byte[3] = in_effect_byte_3;
  assign effect_byte[4] = in_effect_byte_4;
  assign effect_byte[5] = in_effect_byte_5;
  assign effect_byte[6] = in_effect_byte_6;

  // ---------------- music track ----------------
  mvm_pos_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_music_step (
    .pos    (music_pos_r),
    .len    (len_r[0]),
    .pos_nxt(music_pos_step),
    .ended  (music_ended)
  );

  // the music loops forever, so the wrap flag only returns the position to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      music_pos_r <= '0;
    end else if (tick) begin
      music_pos_r <= music_ended ? '0 : music_pos_step;
    end
  end

  assign music_term = $signed({1'b0, in_music_byte}) - CENTER;

  // ---------------- effect voice lanes ----------------
  // voices beyond VOICES are not built: they read as idle at position zero,
  // and a trigger addressed to them matches no lane
  for (genvar v = 0; v < MAX_VOICES; v++) begin : g_lane
    if (v < VOICES) begin : g_on
      mvm_voice_lane #(
        .POSITION_BITS(POSITION_BITS)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .trig       (trigger && (in_voice_select == REG_IDX_W'(v))),
        .plays_added(in_plays_added),
        .len        (len_r[v+1]),
        .sample_byte(effect_byte[v]),
        .res        (lane_res[v])
      );
    end else begin : g_off
      assign lane_res[v] = '0;
    end
  end

  // ---------------- merge and output ----------------
  mvm_mix_out u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .music_term(music_term),
    .music_pos ((music_ended ? POS_OUT_W'(0) : POS_OUT_W'(music_pos_step))),
    .lanes     (lane_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (mix_full)
  );

  assign out_mixed_sample      = out_res.sample;
  assign out_voices_active     = out_res.active;
  assign out_music_position    = out_res.music_pos;
  assign out_effect_position_0 = out_res.effect_pos[0];
  assign out_effect_position_1 = out_res.effect_pos[1];
  assign out_effect_position_2 = out_res.effect_pos[2];
  assign out_effect_position_3 = out_res.effect_pos[3];
  assign out_effect_position_4 = out_res.effect_pos[4];
  assign out_effect_position_5 = out_res.effect_pos[5];
  assign out_effect_position_6 = out_res.effect_pos[6];

endmodule

// File: src/mvm_pos_step.sv
// ----------------------------------------------------------------------------
// mvm_pos_step
// advances a byte position by one and wraps it at the track length
// ----------------------------------------------------------------------------
module mvm_pos_step #(
  parameter int unsigned POSITION_BITS = mvm_pkg::POS_BITS_DEF
) (
  input  logic [POSITION_BITS-1:0]  pos,
  input  logic [mvm_pkg::LEN_W-1:0] len,
  output logic [POSITION_BITS-1:0]  pos_nxt,
  output logic                      ended
);
  import mvm_pkg::*;

  localparam int unsigned CW = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;

  logic [CW-1:0] inc;

  // a length of zero behaves like one: every byte is the last
  assign inc     = CW'(pos) + CW'(1);
  assign ended   = (inc >= CW'(len));
  assign pos_nxt = ended ? '0 : inc[POSITION_BITS-1:0];

endmodule

// File: src/mvm_voice_lane.sv
// ----------------------------------------------------------------------------
// mvm_voice_lane
// one effect voice: play count, byte position and centered contribution
// ----------------------------------------------------------------------------
module mvm_voice_lane #(
  parameter int unsigned POSITION_BITS = mvm_pkg::POS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  logic                        trig,
  input  logic [mvm_pkg::COUNT_W-1:0] plays_added,
  input  logic [mvm_pkg::LEN_W-1:0]   len,
  input  logic [7:0]                  sample_byte,
  output mvm_pkg::lane_res_t          res
);
  import mvm_pkg::*;

  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] step_pos;
  logic                     step_ended;
  logic [COUNT_W:0]         sat_sum;
  logic signed [TERM_W-1:0] term;

  mvm_pos_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .pos    (pos_r),
    .len    (len),
    .pos_nxt(step_pos),
    .ended  (step_ended)
  );

  assign sat_sum = {1'b0, count_r} + {1'b0, plays_added};

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    term      = '0;
    if (trig) begin
      count_nxt = sat_sum[COUNT_W] ? COUNT_MAX : sat_sum[COUNT_W-1:0];
    end else if (tick && (count_r != '0)) begin
      term    = $signed({1'b0, sample_byte}) - CENTER;
      pos_nxt = step_pos;
      // end of a play: drop one play, position already back at zero
      if (step_ended) begin
        count_nxt = count_r - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign res.active = (count_nxt != '0);
  assign res.pos    = POS_OUT_W'(pos_nxt);
  assign res.term   = term;

  // an idle voice always sits at position zero
  a_idle_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (pos_r == '0))
    else $error("idle voice has nonzero position");

endmodule

// File: src/mvm_mix_out.sv
// ----------------------------------------------------------------------------
// mvm_mix_out
// sums music and lane contributions and holds results in an output skid pair
// ----------------------------------------------------------------------------
module mvm_mix_out (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        push,
  input  logic signed [mvm_pkg::TERM_W-1:0]           music_term,
  input  logic [mvm_pkg::POS_OUT_W-1:0]               music_pos,
  input  mvm_pkg::lane_res_t [mvm_pkg::MAX_VOICES-1:0] lanes,
  input  logic                                        out_stall,
  output logic                                        out_valid,
  output mvm_pkg::res_t                               out_res,
  output logic                                        full
);
  import mvm_pkg::*;

  logic signed [SUM_W-1:0] sum;
  res_t                    new_res;
  res_t                    out_res_r, skid_res_r;
  logic                    out_valid_r, skid_valid_r;
  logic                    pop;

  // sum times 64 wrapped to 16 bits keeps only the low ten bits of the sum
  always_comb begin
    sum = SUM_W'(music_term);
    for (int v = 0; v < MAX_VOICES; v++) begin
      sum = sum + SUM_W'(lanes[v].term);
    end
    new_res.sample    = {sum[SAMPLE_W-GAIN_SHIFT-1:0], GAIN_SHIFT'(0)};
    new_res.music_pos = music_pos;
    for (int v = 0; v < MAX_VOICES; v++) begin
      new_res.active[v]     = lanes[v].active;
      new_res.effect_pos[v] = lanes[v].pos;
    end
  end

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_res_r <= new_res;
      end else begin
        out_res_r <= new_res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign full      = skid_valid_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output is empty");

  a_push_into_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && out_stall && !skid_valid_r) |=> skid_valid_r)
    else $error("result pushed behind a stalled output was lost");

endmodule

// File: tb/sv/looping_music_and_effect_voice_mixer_unit_tb.sv
// ----------------------------------------------------------------------------
// looping_music_and_effect_voice_mixer_unit_tb
// self-checking bench for the looping music and effect voice mixer: a short
// table of hand-picked requests, then randomized triggers and ticks over
// several length settings, every result checked against a cycle-free model
// ----------------------------------------------------------------------------
module looping_music_and_effect_voice_mixer_unit_tb;
  import mvm_pkg::*;

  // register map, one length per word
  localparam int MUSIC_LEN_REG   = 0;
  localparam int EFFECT_LEN_REG0 = 1;

  localparam int BYTE_CENTER   = 127;
  localparam int MIX_GAIN      = 64;
  localparam int NUM_VOICES    = VOICES_DEF;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 4;     // margin for a trailing trigger to land
  localparam int HOLD_CYCLES   = 150;   // long receiver back-pressure stretch
  localparam int CHUNKS        = 6;
  localparam int CHUNK_ITEMS   = 275;
  localparam logic [LEN_W-1:0] LEN_MAX = 25'h1000000;

  // one request as the fetcher and the control side present it
  typedef struct packed {
    op_t                  op;
    logic [2:0]           sel;
    logic [3:0]           plays;
    logic [7:0]           mbyte;
    logic [6:0][7:0]      ebytes;
  } mix_req_t;

  // a directed row; typed rows carry a hand-worked sample and activity mask
  typedef struct packed {
    mix_req_t             req;
    logic                 typed;
    logic signed [15:0]   sample;
    logic [6:0]           active;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = 1'b0;
  logic [2:0]        in_voice_select = '0;
  logic [3:0]        in_plays_added = '0;
  logic [7:0]        in_music_byte = '0;
  logic [6:0][7:0]   effect_bytes = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] out_mixed_sample;
  logic [6:0]        out_voices_active;
  logic [23:0]       out_music_position;
  wire  [6:0][23:0]  dut_effect_pos;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // idle shaping, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // long hold handshake between the stimulus and the receiver process
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int quiet_cycles = 0;

  // model state: playback positions, remaining plays, programmed lengths
  logic [23:0]          music_at;
  logic [23:0]          voice_at [NUM_VOICES];
  logic [3:0]           plays_left [NUM_VOICES];
  logic [LEN_W-1:0]     track_len [NUM_REGS];

  // mixes predicted for accepted ticks, oldest first
  res_t pending_mixes [$];

  stim_row_t directed_rows [20];

  // 4 time unit clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  looping_music_and_effect_voice_mixer_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_voice_select       (in_voice_select),
    .in_plays_added        (in_plays_added),
    .in_music_byte         (in_music_byte),
    .in_effect_byte_0      (effect_bytes[0]),
    .in_effect_byte_1      (effect_bytes[1]),
    .in_effect_byte_2      (effect_bytes[2]),
    .in_effect_byte_3      (effect_bytes[3]),
    .in_effect_byte_4      (effect_bytes[4]),
    .in_effect_byte_5      (effect_bytes[5]),
    .in_effect_byte_6      (effect_bytes[6]),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mixed_sample      (out_mixed_sample),
    .out_voices_active     (out_voices_active),
    .out_music_position    (out_music_position),
    .out_effect_position_0 (dut_effect_pos[0]),
    .out_effect_position_1 (dut_effect_pos[1]),
    .out_effect_position_2 (dut_effect_pos[2]),
    .out_effect_position_3 (dut_effect_pos[3]),
    .out_effect_position_4 (dut_effect_pos[4]),
    .out_effect_position_5 (dut_effect_pos[5]),
    .out_effect_position_6 (dut_effect_pos[6]),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  // next byte position; ended flags that pos was the last byte of the track
  function automatic logic [23:0] step_pos(input logic [23:0] pos,
                                           input logic [LEN_W-1:0] len,
                                           output bit ended);
    logic [25:0] nxt;
    nxt = {2'b00, pos} + 26'd1;
    // a zero length falls in here too, so it acts like a length of one
    if (nxt >= {1'b0, len}) begin
      ended = 1'b1;
      return '0;
    end
    ended = 1'b0;
    return nxt[23:0];
  endfunction

  // apply one accepted request to the model; returns 1 when it yields a mix
  function automatic bit mix_step(input mix_req_t r, output res_t res);
    int acc;
    int total;
    bit ended;
    res = '0;
    if (r.op == OP_TRIGGER) begin
      // selects past the last voice are dropped, counts clamp at the top
      if (r.sel < NUM_VOICES) begin
        total = int'(plays_left[r.sel]) + int'(r.plays);
        plays_left[r.sel] = (total > int'(COUNT_MAX)) ? COUNT_MAX : total[3:0];
      end
      return 1'b0;
    end
    acc = int'(r.mbyte) - BYTE_CENTER;
    music_at = step_pos(music_at, track_len[MUSIC_LEN_REG], ended);
    for (int v = 0; v < NUM_VOICES; v++) begin
      // an idle voice contributes nothing and keeps its position
      if (plays_left[v] != '0) begin
        acc += int'(r.ebytes[v]) - BYTE_CENTER;
        voice_at[v] = step_pos(voice_at[v], track_len[EFFECT_LEN_REG0 + v], ended);
        if (ended) begin
          plays_left[v] = plays_left[v] - 4'd1;
        end
      end
    end
    for (int v = 0; v < NUM_VOICES; v++) begin
      res.active[v] = (plays_left[v] != '0);
      res.effect_pos[v] = voice_at[v];
    end
    res.sample = 16'(acc * MIX_GAIN);
    res.music_pos = music_at;
    return 1'b1;
  endfunction

  function automatic stim_row_t tick_row(input logic [7:0] mb, input logic [6:0][7:0] eb,
                                         input bit typed, input logic signed [15:0] s,
                                         input logic [6:0] act);
    stim_row_t row;
    row = '0;
    row.req.op = OP_TICK;
    row.req.mbyte = mb;
    row.req.ebytes = eb;
    row.typed = typed;
    row.sample = s;
    row.active = act;
    return row;
  endfunction

  function automatic stim_row_t trig_row(input logic [2:0] sel, input logic [3:0] plays);
    stim_row_t row;
    row = '0;
    row.req.op = OP_TRIGGER;
    row.req.sel = sel;
    row.req.plays = plays;
    return row;
  endfunction

  // byte with extra weight on the extremes and the center level
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'd127;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one request, wait for it to be taken, then predict its mix
  task automatic push_request(input mix_req_t r, input bit typed,
                              input logic signed [15:0] t_sample, input logic [6:0] t_active);
    res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= r.op;
    in_voice_select <= r.sel;
    in_plays_added <= r.plays;
    in_music_byte <= r.mbyte;
    effect_bytes <= r.ebytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mix_step(r, want)) begin
      // hand-worked rows override the sample and mask, positions still modeled
      if (typed) begin
        want.sample = t_sample;
        want.active = t_active;
      end
      pending_mixes.push_back(want);
    end
  endtask

  // stop offering and wait until every predicted mix has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_mixes.size() != 0);
  endtask

  // one register access: setup phase, access phase, then back to idle
  task automatic reg_access(input bit wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write every length with junk above bit 24, read it back, mirror it in the model
  task automatic program_lengths(input logic [NUM_REGS-1:0][LEN_W-1:0] lens);
    logic [DATA_W-1:0] got;
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_access(1'b1, i, {7'($urandom), lens[i]}, got);
      reg_access(1'b0, i, '0, got);
      if (got !== 32'(lens[i])) begin
        report_mismatch($sformatf("length register %0d readback", i), got, lens[i]);
      end
      track_len[i] = lens[i];
    end
  endtask

  // receiver: random back-pressure, or a long hold when the stimulus asks
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker: every transferred mix against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mixes.size() == 0) begin
        report_mismatch("result with no request pending", out_mixed_sample, 0);
      end else begin
        want = pending_mixes.pop_front();
        if (out_mixed_sample !== want.sample) begin
          report_mismatch("mixed_sample", 16'(out_mixed_sample), 16'(want.sample));
        end
        if (out_voices_active !== want.active) begin
          report_mismatch("voices_active", out_voices_active, want.active);
        end
        if (out_music_position !== want.music_pos) begin
          report_mismatch("music_position", out_music_position, want.music_pos);
        end
        for (int v = 0; v < MAX_VOICES; v++) begin
          if (dut_effect_pos[v] !== want.effect_pos[v]) begin
            report_mismatch($sformatf("effect_position_%0d", v), dut_effect_pos[v],
                            want.effect_pos[v]);
          end
        end
      end
    end
  end

  // watchdog: any transfer on either channel or the register port restarts it
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DATA_W-1:0] got;
    logic [NUM_REGS-1:0][LEN_W-1:0] lens;
    mix_req_t req;

    // model starts where the block comes out of reset
    music_at = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      voice_at[v] = '0;
      plays_left[v] = '0;
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      track_len[i] = LEN_RESET;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every length comes up as one
    for (int i = 0; i < NUM_REGS; i++) begin
      reg_access(1'b0, i, '0, got);
      if (got !== 32'(LEN_RESET)) begin
        report_mismatch($sformatf("length register %0d after reset", i), got, LEN_RESET);
      end
    end

    // directed rows, all lengths still one so every play lasts a single tick
    directed_rows = '{
      tick_row(8'd127, {7{8'h00}}, 1'b1, 16'sd0, 7'h00),      // silence
      tick_row(8'hFF, {7{8'h00}}, 1'b1, 16'sd8192, 7'h00),    // music at its top
      tick_row(8'h00, {7{8'h00}}, 1'b1, -16'sd8128, 7'h00),   // music at its bottom
      tick_row(8'd127, {7{8'hFF}}, 1'b1, 16'sd0, 7'h00),      // idle voices ignored
      trig_row(3'd7, 4'd15),                                  // no such voice
      trig_row(3'd0, 4'd0),                                   // adds nothing
      trig_row(3'd0, 4'd15),
      trig_row(3'd0, 4'd15),                                  // count clamps at 15
      tick_row(8'hFF, {{6{8'h00}}, 8'hFF}, 1'b1, 16'sd16384, 7'h01),
      trig_row(3'd1, 4'd15),
      trig_row(3'd2, 4'd15),
      trig_row(3'd3, 4'd15),
      trig_row(3'd4, 4'd15),
      trig_row(3'd5, 4'd15),
      trig_row(3'd6, 4'd15),
      tick_row(8'hFF, {7{8'hFF}}, 1'b1, 16'sd0, 7'h7F),       // full scale up wraps to 0
      tick_row(8'h00, {7{8'h00}}, 1'b1, 16'sd512, 7'h7F),     // full scale down wraps
      tick_row(8'hFF, {{4{8'd127}}, {3{8'hFF}}}, 1'b1, 16'sh8000, 7'h7F),
      tick_row(8'hFF, {{4{8'd127}}, 8'hFE, 8'hFF, 8'hFF}, 1'b1, 16'sh7FC0, 7'h7F),
      tick_row(8'h5A, {8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 8'h33, 8'hC4}, 1'b0, 16'sd0, 7'h00)
    };

    send_idle_pct = 27;
    recv_stall_pct = 88;
    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].sample, directed_rows[i].active);
    end

    // random part: each chunk starts idle, gets new lengths, then a request stream
    for (int c = 0; c < CHUNKS; c++) begin
      drain_results();
      // a trailing trigger leaves no result to wait on, so give it time to land
      repeat (SETTLE_CYCLES) @(posedge clk);

      case (c)
        0: begin
          lens[MUSIC_LEN_REG] = 25'($urandom_range(1, 16));
          for (int v = 0; v < NUM_VOICES; v++)
            lens[EFFECT_LEN_REG0 + v] = 25'($urandom_range(1, 6));
        end
        1: begin
          // longest music track, shortest effects
          lens[MUSIC_LEN_REG] = LEN_MAX;
          for (int v = 0; v < NUM_VOICES; v++) lens[EFFECT_LEN_REG0 + v] = 25'd1;
        end
        2: begin
          lens[MUSIC_LEN_REG] = 25'($urandom_range(1, 8));
          for (int v = 0; v < NUM_VOICES; v++)
            lens[EFFECT_LEN_REG0 + v] = 25'($urandom_range(1, 12));
        end
        3: begin
          // extremes, plus a zero length and the all-ones register value
          lens[MUSIC_LEN_REG] = 25'h1FFFFFF;
          lens[EFFECT_LEN_REG0 + 0] = 25'd0;
          lens[EFFECT_LEN_REG0 + 1] = LEN_MAX;
          lens[EFFECT_LEN_REG0 + 2] = 25'd1;
          lens[EFFECT_LEN_REG0 + 3] = 25'h1FFFFFF;
          lens[EFFECT_LEN_REG0 + 4] = 25'd2;
          lens[EFFECT_LEN_REG0 + 5] = LEN_MAX;
          lens[EFFECT_LEN_REG0 + 6] = 25'd1;
        end
        4: begin
          lens[MUSIC_LEN_REG] = 25'($urandom_range(1, 4));
          for (int v = 0; v < NUM_VOICES; v++)
            lens[EFFECT_LEN_REG0 + v] = 25'($urandom_range(1, 3));
        end
        default: begin
          lens[MUSIC_LEN_REG] = 25'($urandom_range(1, 64));
          for (int v = 0; v < NUM_VOICES; v++)
            lens[EFFECT_LEN_REG0 + v] = 25'($urandom_range(1, 40));
        end
      endcase
      program_lengths(lens);

      // receiver sparse then sender sparse, last two chunks run flat out
      case (c / 2)
        0: begin
          send_idle_pct = 27;
          recv_stall_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        // receiver holds off for a long stretch while requests keep coming
        if (c == 4 && n == 60) hold_asked++;
        // sender pauses until the pipe is empty, then resumes
        if (c == 2 && n == 140) drain_results();

        req = '0;
        if ($urandom_range(99) < 20) begin
          req.op = OP_TRIGGER;
          req.sel = 3'($urandom_range(0, 7));
          req.plays = 4'($urandom_range(0, 15));
          // bytes ride along on triggers too and must be ignored
          req.mbyte = 8'($urandom);
          req.ebytes = 56'({$urandom, $urandom});
        end else begin
          req.op = OP_TICK;
          req.sel = 3'($urandom_range(0, 7));
          req.plays = 4'($urandom_range(0, 15));
          req.mbyte = pick_byte();
          for (int v = 0; v < MAX_VOICES; v++) req.ebytes[v] = pick_byte();
        end
        push_request(req, 1'b0, 16'sd0, 7'h00);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
